@@ sv/moving_average_with_rail_fault_top_assert.svh @@
// Assertion macros for the moving average block.
`ifndef MOVING_AVERAGE_WITH_RAIL_FAULT_TOP_ASSERT_SVH
`define MOVING_AVERAGE_WITH_RAIL_FAULT_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define MAWRF_ASSERT_HOLDS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// Consequent must hold in the same cycle as the antecedent.
`define MAWRF_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define MAWRF_ASSERT_HOLDS(lbl, expr, msg)
`define MAWRF_ASSERT_IMPLIES(lbl, ante, cons, msg)
`endif
`endif

@@ sv/mawrf_pkg.sv @@
// Shared constants for the moving average block.
package mawrf_pkg;

    // Default sizing
    localparam int WINDOW_DEF      = 16;
    localparam int SAMPLE_BITS_DEF = 12;

    // Fixed port field widths
    localparam int SAMPLE_W  = 12;
    localparam int AVG_W     = 20;
    localparam int COUNT_W   = 5;
    localparam int THRESH_W  = 12;
    localparam int FRAC_BITS = 8;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 12'hFFF;

endpackage

@@ sv/mawrf_if.sv @@
// Valid/ready channel interfaces for samples, results and the threshold register.
interface mawrf_in_if
    import mawrf_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface mawrf_out_if
    import mawrf_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [AVG_W-1:0]   average_q8;
    logic [COUNT_W-1:0] samples_in_window;
    logic               sensor_fault;

    modport source (output valid, output average_q8, output samples_in_window,
                    output sensor_fault, input ready);
    modport sink   (input valid, input average_q8, input samples_in_window,
                    input sensor_fault, output ready);
endinterface

interface mawrf_cfg_if
    import mawrf_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [THRESH_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ sv/moving_average_with_rail_fault_top.sv @@
// Boxcar moving average over a sample ring, with a rail fault flag.
//
// Channels: samp takes one 12-bit ADC word per handshake; result gives the
// truncated mean (8 fraction bits), the number of samples averaged and the
// fault flag for that word; cfg writes rail_threshold (always ready). The
// user writes it only while idle; the block does not enforce this. A word is
// flagged when zero or at or above the threshold, and is averaged either way.
// Timing: one word at a time. After acceptance the ring entry is read, the
// total is updated and written back, then a restoring divider produces one
// quotient bit per cycle, and the result register loads once it is free.
// The block takes no new word until that load is done.
// Reset clears the fill count, write position, running total and the result
// valid flag, and sets the threshold to 4095. Ring contents need no clearing:
// an entry is read back only once the ring is full.
// If the receiver stalls, the finished result waits in the result register
// and the next word is still taken and processed; its result is held in the
// divider until the result register frees up.
`include "moving_average_with_rail_fault_top_assert.svh"

module moving_average_with_rail_fault_top
    import mawrf_pkg::*;
#(
    parameter int WINDOW      = WINDOW_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    mawrf_in_if.sink    samp,
    mawrf_out_if.source result,
    mawrf_cfg_if.sink   cfg
);

    localparam int POS_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W   = $clog2(WINDOW + 1);
    localparam int TOTAL_W = $clog2(WINDOW * ((1 << SAMPLE_BITS) - 1) + 1);
    localparam int DVD_W   = TOTAL_W + FRAC_BITS;
    localparam int STEP_W  = $clog2(DVD_W + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    // Sample ring
    logic [SAMPLE_BITS-1:0] ring [WINDOW];
    logic [SAMPLE_BITS-1:0] rd_data_reg;
    logic                   ring_we;

    logic [1:0]             state_reg, state_next;
    logic [THRESH_W-1:0]    thresh_reg, thresh_next;
    logic [SAMPLE_BITS-1:0] smp_reg, smp_next;
    logic                   fault_reg, fault_next;
    logic [POS_W-1:0]       pos_reg, pos_next;
    logic [CNT_W-1:0]       fill_reg, fill_next;
    logic [TOTAL_W-1:0]     total_reg, total_next;
    logic [DVD_W-1:0]       dvd_reg, dvd_next;
    logic [CNT_W:0]         rem_reg, rem_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic                   out_valid_reg, out_valid_next;
    logic [AVG_W-1:0]       out_avg_reg, out_avg_next;
    logic [COUNT_W-1:0]     out_cnt_reg, out_cnt_next;
    logic                   out_fault_reg, out_fault_next;

    logic                      in_fire;
    logic                      ring_full;
    logic [SAMPLE_BITS-1:0]    old_smp;
    logic [SAMPLE_BITS+11:0]   smp_ext;
    logic [CNT_W:0]            rem_shift;
    logic                      q_bit;
    logic                      out_load;
    logic [DVD_W+AVG_W-1:0]    avg_ext;
    logic [CNT_W+COUNT_W-1:0]  cnt_ext;

    assign samp.ready = (state_reg == ST_IDLE);
    assign in_fire    = samp.valid && samp.ready;
    assign cfg.ready  = 1'b1;

    assign smp_ext   = {{SAMPLE_BITS{1'b0}}, samp.sample};
    assign ring_full = (fill_reg == CNT_W'(WINDOW));
    assign old_smp   = ring_full ? rd_data_reg : '0;
    assign ring_we   = (state_reg == ST_READ);

    // One restoring division step
    assign rem_shift = {rem_reg[CNT_W-1:0], dvd_reg[DVD_W-1]};
    assign q_bit     = (rem_shift >= {1'b0, fill_reg});

    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || result.ready);
    assign avg_ext  = {{AVG_W{1'b0}}, dvd_reg};
    assign cnt_ext  = {{COUNT_W{1'b0}}, fill_reg};

    // Ring memory: synchronous read of the current write position
    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring[pos_reg] <= smp_reg;
        end
        rd_data_reg <= ring[pos_reg];
    end

    // Next-state logic
    always_comb
    begin
        state_next     = state_reg;
        thresh_next    = thresh_reg;
        smp_next       = smp_reg;
        fault_next     = fault_reg;
        pos_next       = pos_reg;
        fill_next      = fill_reg;
        total_next     = total_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        out_avg_next   = out_avg_reg;
        out_cnt_next   = out_cnt_reg;
        out_fault_next = out_fault_reg;

        if (cfg.valid)
        begin
            thresh_next = cfg.data;
        end

        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    smp_next   = smp_ext[SAMPLE_BITS-1:0];
                    fault_next = (samp.sample == '0) || (samp.sample >= thresh_reg);
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                // Drop the oldest word once full, add the new one
                total_next = total_reg - TOTAL_W'(old_smp) + TOTAL_W'(smp_reg);
                fill_next  = ring_full ? fill_reg : fill_reg + 1'b1;
                pos_next   = (pos_reg == POS_W'(WINDOW - 1)) ? '0 : pos_reg + 1'b1;
                dvd_next   = {total_next, {FRAC_BITS{1'b0}}};
                rem_next   = '0;
                step_next  = STEP_W'(DVD_W);
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                rem_next  = q_bit ? rem_shift - {1'b0, fill_reg} : rem_shift;
                dvd_next  = {dvd_reg[DVD_W-2:0], q_bit};
                step_next = step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    out_avg_next   = avg_ext[AVG_W-1:0];
                    out_cnt_next   = cnt_ext[COUNT_W-1:0];
                    out_fault_next = fault_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            thresh_reg    <= THRESH_RESET;
            pos_reg       <= '0;
            fill_reg      <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            thresh_reg    <= thresh_next;
            pos_reg       <= pos_next;
            fill_reg      <= fill_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and datapath registers
    always_ff @(posedge clk)
    begin
        smp_reg       <= smp_next;
        fault_reg     <= fault_next;
        dvd_reg       <= dvd_next;
        rem_reg       <= rem_next;
        step_reg      <= step_next;
        out_avg_reg   <= out_avg_next;
        out_cnt_reg   <= out_cnt_next;
        out_fault_reg <= out_fault_next;
    end

    assign result.valid             = out_valid_reg;
    assign result.average_q8        = out_avg_reg;
    assign result.samples_in_window = out_cnt_reg;
    assign result.sensor_fault      = out_fault_reg;

    // Checks
    `MAWRF_ASSERT_HOLDS(a_fill_bounded, fill_reg <= CNT_W'(WINDOW), "fill count past window")
    `MAWRF_ASSERT_IMPLIES(a_pos_tracks_fill, fill_reg < CNT_W'(WINDOW), CNT_W'(pos_reg) == fill_reg, "write position out of step with fill count")
    `MAWRF_ASSERT_IMPLIES(a_rem_below_divisor, state_reg == ST_DIV, rem_reg < (CNT_W + 1)'(fill_reg), "remainder not below divisor")

endmodule

@@ test/tb_top.sv @@
// Testbench for the moving average block with rail fault flag.
`timescale 1ns / 1ps

module tb_top
    import mawrf_pkg::*;
();

    localparam int RING_DEPTH     = WINDOW_DEF;
    localparam int SETTLE_CYCLES  = 60;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

    // One expected result word
    typedef struct packed {
        logic [AVG_W-1:0]   average_q8;
        logic [COUNT_W-1:0] samples_in_window;
        logic               sensor_fault;
    } mean_word_t;

    logic clk;
    logic rst_n;

    mawrf_in_if  samp ();
    mawrf_out_if result ();
    mawrf_cfg_if cfg ();

    moving_average_with_rail_fault_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .samp   (samp.sink),
        .result (result.source),
        .cfg    (cfg.sink)
    );

    // Shadow of the block state
    logic [SAMPLE_W-1:0] shadow_ring [RING_DEPTH];
    logic [3:0]          shadow_pos;
    logic [COUNT_W-1:0]  shadow_fill;
    logic [15:0]         shadow_total;
    logic [THRESH_W-1:0] shadow_rail;

    mean_word_t pending_means [$];
    int         errors;
    int         tx_idle_pct;
    int         rx_stall_pct;
    int         quiet_cycles;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Push one sample into the shadow window and return the expected word
    function automatic mean_word_t advance_window(input logic [SAMPLE_W-1:0] s);
        mean_word_t    w;
        logic [23:0]   scaled;
        if (shadow_fill >= COUNT_W'(RING_DEPTH))
        begin
            shadow_fill  = COUNT_W'(RING_DEPTH);
            shadow_total = shadow_total - 16'(shadow_ring[shadow_pos]);
        end
        else
        begin
            shadow_fill = shadow_fill + 1'b1;
        end
        shadow_ring[shadow_pos] = s;
        shadow_total = shadow_total + 16'(s);
        shadow_pos   = shadow_pos + 1'b1;
        scaled = {shadow_total, 8'b0} / 24'(shadow_fill);
        w.average_q8        = scaled[AVG_W-1:0];
        w.samples_in_window = shadow_fill;
        w.sensor_fault      = (s == '0) || (s >= shadow_rail);
        return w;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        errors++;
    endtask

    // Send one sample word, with a random idle gap first
    task automatic push_sample(input logic [SAMPLE_W-1:0] s);
        int gap = 0;
        while ($urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0)
        begin
            samp.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        samp.valid  <= 1'b1;
        samp.sample <= s;
        @(posedge clk);
        while (!samp.ready)
            @(posedge clk);
        pending_means.push_back(advance_window(s));
    endtask

    // Threshold write; only called with the block idle
    task automatic load_rail_threshold(input logic [THRESH_W-1:0] value);
        cfg.valid <= 1'b1;
        cfg.data  <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        shadow_rail = value;
        cfg.valid <= 1'b0;
    endtask

    // Stop sending, wait for all results, then let the block settle
    task automatic wait_for_quiet();
        samp.valid <= 1'b0;
        @(posedge clk);
        while (pending_means.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Mostly uniform, with weight on zero, full scale and the rail edge
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int v;
        case ($urandom_range(9))
            0: v = 0;
            1: v = int'(SAMPLE_MAX);
            2:
            begin
                v = int'(shadow_rail) + int'($urandom_range(2)) - 1;
                if (v < 0)
                    v = 0;
                if (v > int'(SAMPLE_MAX))
                    v = int'(SAMPLE_MAX);
            end
            default: v = int'($urandom_range(int'(SAMPLE_MAX)));
        endcase
        return SAMPLE_W'(v);
    endfunction

    task automatic run_random_burst(input int n, input int tx_pct, input int rx_pct,
                                    input logic [THRESH_W-1:0] rail);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        load_rail_threshold(rail);
        repeat (n) push_sample(pick_sample());
        wait_for_quiet();
    endtask

    // Reset threshold, field extremes, ring fill and wrap to full-scale mean
    task automatic test_directed_extremes();
        logic [SAMPLE_W-1:0] seq [8];
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        seq = '{12'h000, 12'hFFF, 12'hFFE, 12'h001, 12'h800, 12'h7FF, 12'hAAA, 12'h555};
        foreach (seq[i])
            push_sample(seq[i]);
        // full ring of max words gives the largest mean
        repeat (RING_DEPTH) push_sample(SAMPLE_MAX);
        // zero word after wrap: subtract oldest, still flagged
        push_sample('0);
        wait_for_quiet();
    endtask

    // Zero threshold flags every word
    task automatic test_zero_threshold();
        run_random_burst(10, 0, 0, '0);
    endtask

    task automatic test_no_idle();
        run_random_burst(200, 0, 0, THRESH_W'($urandom_range(4095)));
    endtask

    task automatic test_sender_idle();
        run_random_burst(200, 86, 0, THRESH_W'(1));
    endtask

    task automatic test_receiver_stall();
        run_random_burst(200, 0, 86, THRESH_W'(4095));
    endtask

    task automatic test_both_idle();
        run_random_burst(215, 23, 23, THRESH_W'($urandom_range(4095)));
    endtask

    // Result sink: random ready and compare against the oldest expectation
    always @(posedge clk)
    begin
        mean_word_t want;
        if (rst_n && result.valid && result.ready)
        begin
            if (pending_means.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word avg=%0h cnt=%0d fault=%0b",
                    result.average_q8, result.samples_in_window, result.sensor_fault));
            end
            else
            begin
                want = pending_means.pop_front();
                if (result.average_q8 !== want.average_q8)
                    report_mismatch($sformatf("average_q8 got %0h want %0h",
                        result.average_q8, want.average_q8));
                if (result.samples_in_window !== want.samples_in_window)
                    report_mismatch($sformatf("samples_in_window got %0d want %0d",
                        result.samples_in_window, want.samples_in_window));
                if (result.sensor_fault !== want.sensor_fault)
                    report_mismatch($sformatf("sensor_fault got %0b want %0b",
                        result.sensor_fault, want.sensor_fault));
            end
        end
        result.ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // Watchdog on cycles without any accepted word
    always @(posedge clk)
    begin
        if (!rst_n || (samp.valid && samp.ready) || (result.valid && result.ready)
            || (cfg.valid && cfg.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TIMEOUT at %0t", $time);
            $display("== FAIL ==");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Main sequence
    initial
    begin
        rst_n        = 1'b0;
        samp.valid   = 1'b0;
        samp.sample  = '0;
        cfg.valid    = 1'b0;
        cfg.data     = '0;
        errors       = 0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        shadow_pos   = '0;
        shadow_fill  = '0;
        shadow_total = '0;
        shadow_rail  = THRESH_RESET;
        foreach (shadow_ring[i])
            shadow_ring[i] = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_extremes();
        test_zero_threshold();
        test_no_idle();
        test_sender_idle();
        test_receiver_stall();
        test_both_idle();

        if (pending_means.size() != 0)
            report_mismatch($sformatf("%0d expected words never arrived",
                pending_means.size()));
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ moving_average_with_rail_fault_top.f @@
+incdir+sv
sv/mawrf_pkg.sv
sv/mawrf_if.sv
sv/moving_average_with_rail_fault_top.sv
test/tb_top.sv
